### sv/vds_pkg.sv
// Shared types and constants for the VXLAN decapsulation stream unit.
package vds_pkg;

	localparam int LANE_W = 64;
	localparam int LANES = 8;
	localparam int HELD = 7;
	localparam int KEEP_W = 64;
	localparam int HELD_KEEP_W = 56;
	localparam int VNI_W = 24;
	localparam int VNI_LSB = 8;
	localparam int TAIL_KEEP_BIT = 55;

	typedef logic [LANE_W-1:0] lane_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_PASS  = 2'd1,
		PH_DROP  = 2'd3
	} phase_t;

	// One decoded beat: the joined result plus the pieces of an optional tail result
	typedef struct packed {
		lane_t [LANES-1:0]       lane;
		logic [KEEP_W-1:0]       keep;
		logic                    last;
		logic                    tail;
		lane_t [HELD-1:0]        tail_lane;
		logic [HELD_KEEP_W-1:0]  tail_keep;
	} cmd_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		logic [KEEP_W-1:0] keep;
		logic              last;
	} res_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_rd_t;

endpackage

### sv/vds_in_if.sv
// Input beat channel: valid/ready handshake with the encapsulated beat payload.
interface vds_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] in_lane0;
	logic [63:0] in_lane1;
	logic [63:0] in_lane2;
	logic [63:0] in_lane3;
	logic [63:0] in_lane4;
	logic [63:0] in_lane5;
	logic [63:0] in_lane6;
	logic [63:0] in_lane7;
	logic [63:0] in_keep;
	logic        in_last;

	modport source (
		output valid, in_lane0, in_lane1, in_lane2, in_lane3, in_lane4, in_lane5, in_lane6,
		output in_lane7, in_keep, in_last,
		input  ready
	);
	modport sink (
		input  valid, in_lane0, in_lane1, in_lane2, in_lane3, in_lane4, in_lane5, in_lane6,
		input  in_lane7, in_keep, in_last,
		output ready
	);
endinterface

### sv/vds_out_if.sv
// Output beat channel: valid/ready handshake with the stripped beat payload.
interface vds_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_lane0;
	logic [63:0] out_lane1;
	logic [63:0] out_lane2;
	logic [63:0] out_lane3;
	logic [63:0] out_lane4;
	logic [63:0] out_lane5;
	logic [63:0] out_lane6;
	logic [63:0] out_lane7;
	logic [63:0] out_keep;
	logic        out_last;

	modport source (
		output valid, out_lane0, out_lane1, out_lane2, out_lane3, out_lane4, out_lane5,
		output out_lane6, out_lane7, out_keep, out_last,
		input  ready
	);
	modport sink (
		input  valid, out_lane0, out_lane1, out_lane2, out_lane3, out_lane4, out_lane5,
		input  out_lane6, out_lane7, out_keep, out_last,
		output ready
	);
endinterface

### sv/vds_front.sv
// Front end: VNI check, packet phase tracking and beat realignment into commands.
module vds_front import vds_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [VNI_W-1:0]    cfg_wr_data,
	vds_in_if.sink              ingress,
	input  logic                q_full,
	output q_wr_t               q_wr
);

	phase_t                 phase_q, phase_d;
	logic [VNI_W-1:0]       match_vni_q;
	lane_t [HELD-1:0]       held_lanes_q;
	logic [HELD_KEEP_W-1:0] held_keep_q;
	lane_t [HELD-1:0]       beat_lo;
	logic                   accept;
	logic                   vni_hit;

	assign ingress.ready = !q_full;
	assign accept = ingress.valid && ingress.ready;
	assign beat_lo = {ingress.in_lane6, ingress.in_lane5, ingress.in_lane4, ingress.in_lane3,
		ingress.in_lane2, ingress.in_lane1, ingress.in_lane0};
	assign vni_hit = ingress.in_lane7[VNI_LSB +: VNI_W] == match_vni_q;

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				PH_DROP: begin
					if (ingress.in_last)
						phase_d = PH_START;
				end
				PH_PASS: begin
					phase_d = ingress.in_last ? PH_START : PH_PASS;
				end
				default: begin
					if (!vni_hit)
						phase_d = ingress.in_last ? PH_START : PH_DROP;
					else
						phase_d = ingress.in_last ? PH_START : PH_PASS;
				end
			endcase
		end
	end

	always_comb begin
		q_wr.push = 1'b0;
		q_wr.cmd.lane = {held_lanes_q, ingress.in_lane7};
		q_wr.cmd.keep = {held_keep_q, ingress.in_keep[KEEP_W-1 -: 8]};
		q_wr.cmd.last = 1'b0;
		q_wr.cmd.tail = 1'b0;
		q_wr.cmd.tail_lane = beat_lo;
		q_wr.cmd.tail_keep = ingress.in_keep[HELD_KEEP_W-1:0];
		case (phase_q)
			PH_DROP: begin
				q_wr.push = 1'b0;
			end
			PH_PASS: begin
				// last beat with data below its top 8 bytes spills into a tail result
				q_wr.push = accept;
				q_wr.cmd.last = ingress.in_last && !ingress.in_keep[TAIL_KEEP_BIT];
				q_wr.cmd.tail = ingress.in_last && ingress.in_keep[TAIL_KEEP_BIT];
			end
			default: begin
				// single-beat matching packet: header byte slots come out empty
				q_wr.push = accept && vni_hit && ingress.in_last;
				q_wr.cmd.lane = {beat_lo, LANE_W'(0)};
				q_wr.cmd.keep = {ingress.in_keep[HELD_KEEP_W-1:0], 8'h00};
				q_wr.cmd.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			match_vni_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (cfg_wr_en)
				match_vni_q <= cfg_wr_data;
		end
	end

	// the held beat is only read on the beat right after it, so every transfer may overwrite it
	always_ff @(posedge clk) begin
		if (accept) begin
			held_lanes_q <= beat_lo;
			held_keep_q <= ingress.in_keep[HELD_KEEP_W-1:0];
		end
	end

endmodule

### sv/vds_queue.sv
// Small register FIFO of decoded commands between front and back end.
module vds_queue import vds_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  q_wr_t                      q_wr,
	input  logic                       pop,
	output q_rd_t                      head,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = count_q == CW'(DEPTH);
	assign count = count_q;
	assign head.valid = count_q != '0;
	assign head.cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (q_wr.push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (q_wr.push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !q_wr.push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr.push)
			entry_q[wr_ptr_q] <= q_wr.cmd;
	end

endmodule

### sv/vds_back.sv
// Back end: expands commands into one or two result beats behind an output register.
module vds_back import vds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_rd_t    head,
	output logic     pop,
	vds_out_if.source egress
);

	res_t res_q;
	logic out_valid_q;
	logic tail_pend_q;
	logic out_free;
	res_t res_a, res_tail;

	assign out_free = !out_valid_q || egress.ready;
	// a command with a tail stays at the head until its second result is loaded
	assign pop = out_free && head.valid && (tail_pend_q || !head.cmd.tail);

	assign res_a.lane = head.cmd.lane;
	assign res_a.keep = head.cmd.keep;
	assign res_a.last = head.cmd.last;
	assign res_tail.lane = {head.cmd.tail_lane, LANE_W'(0)};
	assign res_tail.keep = {head.cmd.tail_keep, 8'h00};
	assign res_tail.last = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tail_pend_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= head.valid;
			if (tail_pend_q)
				tail_pend_q <= 1'b0;
			else if (head.valid && head.cmd.tail)
				tail_pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && head.valid)
			res_q <= tail_pend_q ? res_tail : res_a;
	end

	assign egress.valid = out_valid_q;
	assign egress.out_lane0 = res_q.lane[0];
	assign egress.out_lane1 = res_q.lane[1];
	assign egress.out_lane2 = res_q.lane[2];
	assign egress.out_lane3 = res_q.lane[3];
	assign egress.out_lane4 = res_q.lane[4];
	assign egress.out_lane5 = res_q.lane[5];
	assign egress.out_lane6 = res_q.lane[6];
	assign egress.out_lane7 = res_q.lane[7];
	assign egress.out_keep = res_q.keep;
	assign egress.out_last = res_q.last;

endmodule

### sv/vxlan_decapsulation_stream_unit.sv
// VXLAN decapsulation for a 512-bit beat stream. The block accepts one beat per clock
// while its command queue (QUEUE_DEPTH entries) has room; the front end checks the VNI
// of each first beat against match_vni, drops non-matching packets and strips the
// 8-byte header by joining the low 56 bytes of each beat with the top 8 bytes of the
// next. The back end delivers one result per clock from an output register while egress
// is ready; each result passes through the command queue and then the output register.
// A last beat that still carries bytes below its top 8 produces two results; its command
// stays at the head until both are loaded. Sustained output is one result per cycle, set
// by the single result port. A write to match_vni applies from the next first beat on.
module vxlan_decapsulation_stream_unit import vds_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [VNI_W-1:0] cfg_wr_data,
	vds_in_if.sink           ingress,
	vds_out_if.source        egress
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	q_wr_t         q_wr;
	q_rd_t         q_head;
	logic          q_full;
	logic          q_pop;
	logic [CW-1:0] q_count;

	vds_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ingress     (ingress),
		.q_full      (q_full),
		.q_wr        (q_wr)
	);

	vds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.count  (q_count)
	);

	vds_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.egress (egress)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_full)
		else $error("command pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_count != '0)
		else $error("command popped from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> q_count == CW'($past(q_count) + $past(q_wr.push) - $past(q_pop)))
		else $error("queue fill count out of step with push/pop");

endmodule
